[rtl/tsd_pkg.sv]
// Shared types, constants and the digit pattern table for the temperature display.
`default_nettype none

package tsd_pkg;

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_READING = 2'd1,
		MODE_PRESS   = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	localparam int unsigned READING_W = 16;
	localparam int unsigned SEG_W     = 8;
	localparam int unsigned DIGITS    = 4;
	localparam int unsigned HALF_W    = 5;
	localparam int unsigned FRAME_W   = HALF_W + 1;

	localparam logic [HALF_W-1:0]  HALF_RESET = 5'd30;
	localparam logic [SEG_W-1:0]   SEG_MINUS  = 8'h40;
	localparam logic [SEG_W-1:0]   SEG_BLANK  = 8'h00;
	localparam logic [SEG_W-1:0]   SEG_POINT  = 8'h80;

	// Digit position codes, tenths at the right.
	localparam logic [1:0] POS_TENTHS = 2'd0;
	localparam logic [1:0] POS_ONES   = 2'd1;
	localparam logic [1:0] POS_TENS   = 2'd2;
	localparam logic [1:0] POS_SIGN   = 2'd3;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7c;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h67;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/tsd_digit.sv]
// Decodes a half-degree temperature word into the pattern of one display digit.
`default_nettype none

module tsd_digit (
	input  wire logic [tsd_pkg::READING_W-1:0] word,
	input  wire logic [1:0]                    idx,
	output logic      [tsd_pkg::SEG_W-1:0]     seg
);

	logic                               negative;
	logic [tsd_pkg::READING_W-1:0]      mag;
	logic [6:0]                         whole;
	logic [14:0]                        prod;
	logic [3:0]                         quot;
	logic [6:0]                         rem_full;
	logic [3:0]                         ones;
	logic [3:0]                         tens;

	assign negative = word[tsd_pkg::READING_W-1];
	// The most negative word negates to itself and keeps only its sign.
	assign mag      = negative ? (~word + 16'd1) : word;
	assign whole    = mag[14:8];

	// Divide by ten through a reciprocal; exact for the whole 7-bit range.
	assign prod     = 15'(whole) * 15'd205;
	assign quot     = prod[14:11];
	assign rem_full = whole - (7'(quot) * 7'd10);
	assign ones     = rem_full[3:0];
	assign tens     = (quot >= 4'd10) ? (quot - 4'd10) : quot;

	always_comb begin
		case (idx)
			tsd_pkg::POS_TENTHS: seg = tsd_pkg::seg_of(mag[7] ? 4'd5 : 4'd0);
			tsd_pkg::POS_ONES:   seg = tsd_pkg::seg_of(ones) | tsd_pkg::SEG_POINT;
			tsd_pkg::POS_TENS:   seg = tsd_pkg::seg_of(tens);
			default:             seg = negative ? tsd_pkg::SEG_MINUS : tsd_pkg::SEG_BLANK;
		endcase
	end

endmodule

`default_nettype wire

[rtl/temperature_segment_display.sv]
// Top level of the multiplexed four-digit temperature display driver.
//
//  channel | direction | handshake                       | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready   | tdata reading, tuser mode
//  m_axis  | out       | m_axis_tvalid / m_axis_tready   | segments, digit_enable, sample_request
//  cfg     | in        | cfg_valid / cfg_ready           | blink_half_frames
//
// One item is taken every cycle while the input side is not stalled; a tick item's result
// reaches the output through the input register, then the result register, and stays
// there until it is taken.
// Readings and presses update state only; the unused mode does nothing; neither gives a result.
// When the result register is full and not taken, tick items wait in the input
// register and the input side stalls; other items still drain.
// Reset returns to live mode, digit 0, frame 0 and a half period of 30 frames.
`default_nettype none

module temperature_segment_display (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] reading
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [7:0] segments, [11:8] digit_enable,
	                                        // [12] sample_request, [15:13] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data       // [4:0] blink_half_frames
);

	logic [tsd_pkg::HALF_W-1:0]    half_cfg_q;
	logic [tsd_pkg::HALF_W-1:0]    half;
	logic [tsd_pkg::FRAME_W-1:0]   period;

	logic                          valid_s1;
	tsd_pkg::mode_t                mode_s1;
	logic [tsd_pkg::READING_W-1:0] reading_s1;
	logic                          adv_s1;
	logic                          tick_s1;

	logic [tsd_pkg::READING_W-1:0] shown_q;
	logic                          hold_q;
	logic [1:0]                    digit_q;
	logic [tsd_pkg::FRAME_W-1:0]   frame_q;
	logic [tsd_pkg::FRAME_W:0]     frame_next;

	logic [tsd_pkg::SEG_W-1:0]     pattern;
	logic [tsd_pkg::SEG_W-1:0]     seg_d;
	logic [tsd_pkg::DIGITS-1:0]    en_d;
	logic                          req_d;
	logic                          shown_on;

	logic                          out_valid_q;
	logic [15:0]                   out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cfg_q <= tsd_pkg::HALF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_cfg_q <= cfg_data;
		end
	end

	assign half   = (half_cfg_q == '0) ? tsd_pkg::HALF_W'(1) : half_cfg_q;
	assign period = {half, 1'b0};

	// Input register.
	assign tick_s1       = (mode_s1 == tsd_pkg::MODE_TICK);
	assign adv_s1        = valid_s1 && (!tick_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1    <= tsd_pkg::mode_t'(s_axis_tuser);
			reading_s1 <= s_axis_tdata;
		end
	end

	tsd_digit u_digit (
		.word (shown_q),
		.idx  (digit_q),
		.seg  (pattern)
	);

	assign shown_on = !hold_q || (frame_q < tsd_pkg::FRAME_W'(half));

	always_comb begin
		req_d = !hold_q && (digit_q == tsd_pkg::POS_TENTHS) &&
			((frame_q == '0) || (frame_q == tsd_pkg::FRAME_W'(half)));
		seg_d = shown_on ? pattern : tsd_pkg::SEG_BLANK;
		en_d  = shown_on ? (tsd_pkg::DIGITS'(1) << digit_q) : '0;
	end

	assign frame_next = {1'b0, frame_q} + 7'd1;

	// Display state advances as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			hold_q  <= 1'b0;
			digit_q <= '0;
			frame_q <= '0;
		end else if (adv_s1) begin
			case (mode_s1)
				tsd_pkg::MODE_TICK: begin
					if (digit_q == tsd_pkg::POS_SIGN) begin
						digit_q <= '0;
						frame_q <= (frame_next >= {1'b0, period}) ? '0
							: frame_next[tsd_pkg::FRAME_W-1:0];
					end else begin
						digit_q <= digit_q + 2'd1;
					end
				end
				tsd_pkg::MODE_READING: begin
					if (!hold_q) begin
						shown_q <= reading_s1;
					end
				end
				tsd_pkg::MODE_PRESS: begin
					hold_q <= !hold_q;
					if (!hold_q) begin
						shown_q <= reading_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && tick_s1) begin
			out_data_q <= {3'b000, req_d, en_d, seg_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A held item that cannot move must still be there next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input register item lost while stalled");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q < 6'd62)
		else $error("frame count out of range");

	a_enable_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tdata[11:8]))
		else $error("digit enable is not one-hot");

	a_request_digit0: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11:8] == 4'b0001)
		else $error("sample request outside the first digit");

	a_blank_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11:8] == 4'b0000 |-> m_axis_tdata[7:0] == 8'h00)
		else $error("segments lit while blanked");

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the multiplexed temperature display driver.
`timescale 1ns / 100ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned SETTLE      = 6;

	typedef struct packed {
		tsd_pkg::mode_t mode;
		logic [15:0]    reading;
	} stim_t;

	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] digit_enable;
		logic       sample_request;
	} digit_out_t;

	localparam logic [7:0] GLYPH [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
		8'h6d, 8'h7c, 8'h07, 8'h7f, 8'h67};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] reading
	logic [1:0]  s_axis_tuser = tsd_pkg::MODE_TICK;  // [1:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // [7:0] segments, [11:8] digit_enable, [12] sample_request
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;  // [4:0] blink_half_frames

	stim_t       send_q[$];
	digit_out_t  expected_digits[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycles = 0;

	// Predicted display state.
	logic [4:0]  half_frames = tsd_pkg::HALF_RESET;
	logic [15:0] disp_word = '0;
	logic        in_hold = 1'b0;
	logic [1:0]  cur_pos = tsd_pkg::POS_TENTHS;
	logic [5:0]  cur_frame = '0;

	int unsigned tx_wait = 0, tx_steady = 0;
	int unsigned rx_wait = 0, rx_steady = 0, rx_hold = 0;
	bit          long_hold_done = 1'b0;
	stim_t       next_item;

	temperature_segment_display i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] glyph_at(input logic [15:0] word, input logic [1:0] pos);
		logic        neg;
		logic [15:0] mag;
		int unsigned whole;
		neg = word[15];
		mag = neg ? (~word + 16'd1) : word;
		whole = mag[14:8];
		case (pos)
			tsd_pkg::POS_TENTHS: return GLYPH[mag[7] ? 5 : 0];
			tsd_pkg::POS_ONES:   return GLYPH[whole % 10] | tsd_pkg::SEG_POINT;
			tsd_pkg::POS_TENS:   return GLYPH[(whole / 10) % 10];
			default:             return neg ? tsd_pkg::SEG_MINUS : tsd_pkg::SEG_BLANK;
		endcase
	endfunction

	task automatic display_step(input tsd_pkg::mode_t mode, input logic [15:0] reading);
		digit_out_t  res;
		int unsigned half, nxt;
		half = (half_frames == 0) ? 1 : half_frames;
		case (mode)
			tsd_pkg::MODE_READING: begin
				if (!in_hold)
					disp_word = reading;
			end
			tsd_pkg::MODE_PRESS: begin
				if (!in_hold)
					disp_word = reading;
				in_hold = !in_hold;
			end
			tsd_pkg::MODE_TICK: begin
				res = '0;
				if (!in_hold || cur_frame < half) begin
					res.segments = glyph_at(disp_word, cur_pos);
					res.digit_enable = 4'b0001 << cur_pos;
				end
				res.sample_request = !in_hold && cur_pos == tsd_pkg::POS_TENTHS &&
					(cur_frame == 0 || cur_frame == half);
				expected_digits.push_back(res);
				if (cur_pos == tsd_pkg::POS_SIGN) begin
					nxt = cur_frame + 1;
					cur_frame = (nxt >= 2 * half) ? 6'd0 : nxt[5:0];
					cur_pos = tsd_pkg::POS_TENTHS;
				end else begin
					cur_pos = cur_pos + 2'd1;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_random(input int unsigned count);
		stim_t       it;
		int unsigned r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			it.reading = 16'($urandom_range(0, 65535));
			if (r < 68) begin
				it.mode = tsd_pkg::MODE_TICK;
			end else if (r < 80) begin
				it.mode = tsd_pkg::MODE_READING;
			end else if (r < 90) begin
				// Plausible sensor word: low seven bits clear.
				it.mode = tsd_pkg::MODE_READING;
				it.reading = 16'($urandom_range(0, 511) << 7);
			end else if (r < 96) begin
				it.mode = tsd_pkg::MODE_PRESS;
			end else begin
				it.mode = tsd_pkg::MODE_UNUSED;
			end
			send_q.push_back(it);
		end
	endtask

	task automatic queue_reading(input tsd_pkg::mode_t mode, input logic [15:0] word,
		input int unsigned ticks);
		send_q.push_back('{mode, word});
		repeat (ticks)
			send_q.push_back('{tsd_pkg::MODE_TICK, 16'h0000});
	endtask

	// Waits until every item has gone in and every expected result has come out.
	task automatic drain();
		do
			@(negedge clk);
		while (send_q.size() != 0 || s_axis_tvalid || expected_digits.size() != 0);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	task automatic write_half(input logic [4:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Sender: keeps one item on the bus until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_wait != 0) begin
				s_axis_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (send_q.size() != 0) begin
				next_item = send_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_item.reading;
				s_axis_tuser <= next_item.mode;
				if (tx_steady != 0)
					tx_steady <= tx_steady - 1;
				else if ($urandom_range(0, 19) == 0)
					tx_steady <= $urandom_range(30, 120);
				else
					tx_wait <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 200) begin
			long_hold_done <= 1'b1;
			rx_hold <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_steady != 0)
				rx_steady <= rx_steady - 1;
			else if ($urandom_range(0, 19) == 0)
				rx_steady <= $urandom_range(30, 120);
			else if ($urandom_range(0, 3) == 0)
				rx_wait <= pick_gap();
		end
	end

	// Checks each result against the oldest prediction, then predicts from new items.
	always @(posedge clk) begin
		digit_out_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (expected_digits.size() == 0) begin
					$error("unexpected result, tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_digits.pop_front();
					if (m_axis_tdata[7:0] !== want.segments) begin
						$error("segments: expected %h, actual %h", want.segments,
							m_axis_tdata[7:0]);
						mismatches++;
					end
					if (m_axis_tdata[11:8] !== want.digit_enable) begin
						$error("digit_enable: expected %h, actual %h", want.digit_enable,
							m_axis_tdata[11:8]);
						mismatches++;
					end
					if (m_axis_tdata[12] !== want.sample_request) begin
						$error("sample_request: expected %b, actual %b", want.sample_request,
							m_axis_tdata[12]);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				half_frames = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				display_step(tsd_pkg::mode_t'(s_axis_tuser), s_axis_tdata);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("temperature_segment_display regression: fail");
			$finish;
		end
	end

	initial begin
		logic [4:0] settings [7];
		settings = '{5'd1, 5'd31, 5'd0, 5'd2, 5'd7, 5'd30, 5'd3};
		settings[5] = 5'($urandom_range(1, 31));

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset half period.
		repeat (4)
			send_q.push_back('{tsd_pkg::MODE_TICK, 16'h0000});
		queue_reading(tsd_pkg::MODE_READING, 16'h7fff, 4);  // hundreds digit dropped
		queue_reading(tsd_pkg::MODE_READING, 16'h8000, 4);  // most negative word
		queue_reading(tsd_pkg::MODE_READING, 16'hff80, 4);  // minus one half
		queue_reading(tsd_pkg::MODE_PRESS, 16'h1980, 0);    // enter hold, capture 25.5
		queue_reading(tsd_pkg::MODE_READING, 16'h0500, 4);  // ignored while holding
		queue_reading(tsd_pkg::MODE_PRESS, 16'hffff, 0);
		queue_reading(tsd_pkg::MODE_UNUSED, 16'hffff, 1);
		drain();

		foreach (settings[i]) begin
			write_half(settings[i]);
			queue_random(settings[i] == 5'd31 ? 300 : 155);
			drain();
		end

		if (mismatches == 0)
			$display("temperature_segment_display regression: pass");
		else
			$display("temperature_segment_display regression: fail");
		$finish;
	end

endmodule
